@@ sv/pfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// pfdm_pkg: shared types and constants for the pulse frequency / duty meter
// Widths, tick-rate reset value, divider step counts, phase codes and state type.
// ----------------------------------------------------------------------------
package pfdm_pkg;

  localparam int unsigned TimerW   = 16;  // capture timer width
  localparam int unsigned TpsW     = 24;  // tick-rate register width
  localparam int unsigned DutyW    = 7;   // duty quotient width
  localparam int unsigned CntW     = 5;   // divider step counter width

  localparam logic [TpsW-1:0]  TpsReset   = 24'd1000000;
  localparam logic [CntW-1:0]  DutySteps  = 5'd7;   // quotient < 100 fits 7 bits
  localparam logic [CntW-1:0]  FreqSteps  = 5'd24;  // full tick-rate width

  localparam logic [1:0] PhFall   = 2'd1;   // waiting for falling edge
  localparam logic [1:0] PhRise2  = 2'd2;   // waiting for second rising edge
  localparam logic [1:0] PhRise1  = 2'd0;   // waiting for first rising edge

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_DUTY = 5'b00100,
    ST_FREQ = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

@@ sv/pulse_frequency_duty_meter.sv @@
// ----------------------------------------------------------------------------
// pulse_frequency_duty_meter: input-capture frequency and duty-cycle meter
// Takes timer captures of rising, falling, rising edges and reports high time,
// period, duty percent and frequency, or an out-of-range flag.
// ----------------------------------------------------------------------------
// The first two captures of a measurement are stored in the idle state. The
// third capture starts a computation before the result is offered: the load
// state forms high*100, then a shared restoring divider retires one quotient
// bit per cycle, 7 steps for the duty percent and 24 steps for tick_rate/period,
// and the done state moves the result into the output register once it is free.
// A capture sequence that is not strictly increasing skips the divider and goes
// straight to the done state; it is reported with out_out_of_range set and all
// other fields zero. Timer wrap is not corrected. While a result waits in the
// output register the block still takes the next pulse's captures and runs the
// divider; input stalls whenever the sequencer is not idle, including while a
// finished measurement waits for that register to free up.
// ticks_per_second resets to 1000000 and is written through cfg_we/cfg_wdata.
module pulse_frequency_duty_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_capture_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_high_ticks,
  output logic [15:0] out_period_ticks,
  output logic [6:0]  out_duty_percent,
  output logic [15:0] out_frequency_hz,
  output logic        out_out_of_range
);

  pfdm_pkg::state_t state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [23:0] tps_r, tps_nxt;
  logic [15:0] rise_r, rise_nxt;
  logic [15:0] fall_r, fall_nxt;
  logic [15:0] high_r, high_nxt;
  logic [15:0] period_r, period_nxt;
  logic        err_r, err_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [23:0] num_r, num_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_high_r, out_high_nxt;
  logic [15:0] out_period_r, out_period_nxt;
  logic [6:0]  out_duty_r, out_duty_nxt;
  logic [15:0] out_freq_r, out_freq_nxt;
  logic        out_err_r, out_err_nxt;

  logic        in_fire;
  logic        slot_free;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [22:0] mul100;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pfdm_pkg::ST_IDLE);

  // one restoring division step
  assign trial  = {rem_r, num_r[23]};
  assign diff   = trial - {1'b0, period_r};
  assign ge     = (trial >= {1'b0, period_r});
  // high*100 = high*64 + high*32 + high*4
  assign mul100 = {1'b0, high_r, 6'b0} + {2'b0, high_r, 5'b0} + {5'b0, high_r, 2'b0};

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    tps_nxt        = tps_r;
    rise_nxt       = rise_r;
    fall_nxt       = fall_r;
    high_nxt       = high_r;
    period_nxt     = period_r;
    err_nxt        = err_r;
    rem_nxt        = rem_r;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    duty_nxt       = duty_r;
    out_valid_nxt  = out_valid_r;
    out_high_nxt   = out_high_r;
    out_period_nxt = out_period_r;
    out_duty_nxt   = out_duty_r;
    out_freq_nxt   = out_freq_r;
    out_err_nxt    = out_err_r;

    if (cfg_we) begin
      tps_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pfdm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (phase_r == pfdm_pkg::PhFall) begin
            fall_nxt  = in_capture_time;
            phase_nxt = pfdm_pkg::PhRise2;
          end else if (phase_r == pfdm_pkg::PhRise2) begin
            phase_nxt  = pfdm_pkg::PhRise1;
            high_nxt   = fall_r - rise_r;
            period_nxt = in_capture_time - rise_r;
            if (rise_r < fall_r && fall_r < in_capture_time) begin
              err_nxt   = 1'b0;
              state_nxt = pfdm_pkg::ST_LOAD;
            end else begin
              err_nxt   = 1'b1;
              state_nxt = pfdm_pkg::ST_DONE;
            end
          end else begin
            // unused phase code behaves as first rising edge
            rise_nxt  = in_capture_time;
            phase_nxt = pfdm_pkg::PhFall;
          end
        end
      end
      pfdm_pkg::ST_LOAD: begin
        // high < period, so the top 16 bits of high*100 are below period
        rem_nxt   = mul100[22:7];
        num_nxt   = {mul100[6:0], 17'b0};
        quo_nxt   = '0;
        cnt_nxt   = pfdm_pkg::DutySteps;
        state_nxt = pfdm_pkg::ST_DUTY;
      end
      pfdm_pkg::ST_DUTY: begin
        rem_nxt = ge ? diff[15:0] : trial[15:0];
        num_nxt = {num_r[22:0], 1'b0};
        quo_nxt = {quo_r[22:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          duty_nxt  = {quo_r[5:0], ge};
          rem_nxt   = '0;
          num_nxt   = tps_r;
          quo_nxt   = '0;
          cnt_nxt   = pfdm_pkg::FreqSteps;
          state_nxt = pfdm_pkg::ST_FREQ;
        end
      end
      pfdm_pkg::ST_FREQ: begin
        rem_nxt = ge ? diff[15:0] : trial[15:0];
        num_nxt = {num_r[22:0], 1'b0};
        quo_nxt = {quo_r[22:0], ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = pfdm_pkg::ST_DONE;
        end
      end
      pfdm_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          if (err_r) begin
            out_high_nxt   = '0;
            out_period_nxt = '0;
            out_duty_nxt   = '0;
            out_freq_nxt   = '0;
          end else begin
            out_high_nxt   = high_r;
            out_period_nxt = period_r;
            out_duty_nxt   = duty_r;
            out_freq_nxt   = (|quo_r[23:16]) ? 16'hFFFF : quo_r[15:0];
          end
          state_nxt = pfdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfdm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfdm_pkg::ST_IDLE;
      phase_r     <= pfdm_pkg::PhRise1;
      tps_r       <= pfdm_pkg::TpsReset;
      rise_r      <= '0;
      fall_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tps_r       <= tps_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r       <= high_nxt;
    period_r     <= period_nxt;
    err_r        <= err_nxt;
    rem_r        <= rem_nxt;
    num_r        <= num_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    duty_r       <= duty_nxt;
    out_high_r   <= out_high_nxt;
    out_period_r <= out_period_nxt;
    out_duty_r   <= out_duty_nxt;
    out_freq_r   <= out_freq_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_high_ticks   = out_high_r;
  assign out_period_ticks = out_period_r;
  assign out_duty_percent = out_duty_r;
  assign out_frequency_hz = out_freq_r;
  assign out_out_of_range = out_err_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_third_edge_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == pfdm_pkg::PhRise2) |=>
      (state_r == pfdm_pkg::ST_LOAD || state_r == pfdm_pkg::ST_DONE))
    else $error("third edge did not start a measurement");

  a_good_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_err_r) |->
      (out_duty_r <= 7'd100 && out_high_r < out_period_r))
    else $error("valid measurement with inconsistent fields");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      (out_high_r == '0 && out_period_r == '0 && out_duty_r == '0 && out_freq_r == '0))
    else $error("out-of-range result with nonzero fields");

endmodule
